// ===== hdl/mes_pkg.sv =====
// shared types, codes and constants of the mna element stamper
package mes_pkg;

    localparam int DEF_MAX_NODES    = 256;
    localparam int DEF_MAX_VSOURCES = 64;

    localparam int DATA_W  = 32;
    localparam int NODE_W  = 8;
    localparam int ROW_W   = 9;
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;
    localparam int SLOTS   = 5;
    localparam int SLOT_W  = 3;
    localparam int PADDR_W = 3;

    // 2^32 / divisor needs one step per dividend bit
    localparam int RECIP_STEPS = 33;
    localparam int RECIP_CNT_W = $clog2(RECIP_STEPS);

    localparam logic [CMD_W-1:0] CMD_RESISTOR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CURRENT  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_VSOURCE  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd3;

    localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_SHORT    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_UNKNOWN  = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd3;

    localparam logic [0:0] TARGET_MATRIX = 1'b0;
    localparam logic [0:0] TARGET_RHS    = 1'b1;

    localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = 3'd0;

    localparam logic [DATA_W-1:0] Q_ONE       = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_MINUS_ONE = 32'hFFFF_0000;
    localparam logic [DATA_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN       = 32'h8000_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        K_RES,
        K_CUR,
        K_VS,
        K_ERR
    } kind_t;

    // negate with saturation to the signed 32-bit range
    function automatic logic [DATA_W-1:0] sat_neg(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        if (v == Q_MIN) begin
            r = Q_MAX;
        end else begin
            r = DATA_W'(-v);
        end
        return r;
    endfunction

endpackage

// ===== hdl/mes_cfg.sv =====
// apb register block holding node_count
module mes_cfg import mes_pkg::*; #(
    parameter int MAX_NODES = DEF_MAX_NODES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic [ROW_W-1:0]     node_count
);

    localparam int NC_RESET = (MAX_NODES < 256) ? MAX_NODES : 256;

    logic [ROW_W-1:0] node_count_reg;
    logic [ROW_W-1:0] node_count_next;
    logic [ROW_W-1:0] wr_val;
    logic             wr_hit;

    assign wr_val = pwdata[ROW_W-1:0];
    // word decode, low address bits ignored
    assign wr_hit = psel && penable && pwrite && (paddr[PADDR_W-1] == ADDR_NODE_COUNT[PADDR_W-1]);

    always_comb begin
        node_count_next = node_count_reg;
        if (wr_hit) begin
            priority if (wr_val == '0) begin
                node_count_next = ROW_W'(1);
            end else if (DATA_W'(wr_val) > DATA_W'(MAX_NODES)) begin
                node_count_next = ROW_W'(MAX_NODES);
            end else begin
                node_count_next = wr_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= ROW_W'(NC_RESET);
        end else begin
            node_count_reg <= node_count_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1] == ADDR_NODE_COUNT[PADDR_W-1]) begin
            prdata = DATA_W'(node_count_reg);
        end
    end

    assign node_count = node_count_reg;

endmodule

// ===== hdl/mes_recip.sv =====
// radix-2 restoring divider computing 2^32 / divisor
module mes_recip import mes_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DATA_W-1:0] divisor,
    output logic              done,
    output logic [DATA_W:0]   quotient
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [RECIP_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DATA_W-1:0]      div_reg, div_next;
    logic [DATA_W-1:0]      rem_reg, rem_next;
    logic [DATA_W:0]        quo_reg, quo_next;
    logic [DATA_W:0]        trial;
    logic [DATA_W:0]        diff;
    logic                   ge;

    // dividend is a one followed by 32 zeros, fed msb first
    assign trial = {rem_reg, (cnt_reg == '0)};
    assign diff  = trial - {1'b0, div_reg};
    assign ge    = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            div_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-1:0], ge};
            cnt_next = cnt_reg + RECIP_CNT_W'(1);
            if (cnt_reg == RECIP_CNT_W'(RECIP_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/mna_element_stamper.sv =====
// top level: element decode, sequencer and result register of the mna dc stamper
// One element is taken at a time. A resistor runs the bit-serial divider for its
// conductance: the element is accepted, the divider runs, the saturated conductance
// is taken, then the stamp entries (up to 4) follow one after another. Current
// and voltage sources skip the divider and go from acceptance to their entries (up
// to 2 or 5). Errors give a single entry with a nonzero status. The result sits in
// an output register, so the next element is accepted while the final entry of the
// last one still waits; a stalled result receiver holds up the entries behind it.
// node_count is written over the APB port at address 0; voltage source k gets the
// extra row and column node_count-1+k, and a clear command restarts k at zero.
module mna_element_stamper import mes_pkg::*; #(
    parameter int MAX_NODES    = DEF_MAX_NODES,
    parameter int MAX_VSOURCES = DEF_MAX_VSOURCES
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [DATA_W-1:0]         pwdata,
    output logic [DATA_W-1:0]         prdata,
    output logic                      pready,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [CMD_W-1:0]          s_command,
    input  logic [NODE_W-1:0]         s_node_plus,
    input  logic [NODE_W-1:0]         s_node_minus,
    input  logic signed [DATA_W-1:0]  s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_target,
    output logic [ROW_W-1:0]          m_row,
    output logic [ROW_W-1:0]          m_column,
    output logic signed [DATA_W-1:0]  m_amount,
    output logic                      m_last,
    output logic [STAT_W-1:0]         m_status
);

    localparam int VIDX_W = $clog2(MAX_VSOURCES + 1);
    localparam int SUM_W  = ((VIDX_W > ROW_W) ? VIDX_W : ROW_W) + 1;

    state_t              state_reg, state_next;
    kind_t               kind_reg, kind_next;
    logic [SLOTS-1:0]    mask_reg, mask_next;
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [VIDX_W-1:0]   vidx_reg, vidx_next;
    logic [ROW_W-1:0]    p1_reg, p1_next;
    logic [ROW_W-1:0]    m1_reg, m1_next;
    logic [ROW_W-1:0]    r_reg, r_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [DATA_W-1:0]   g_reg, g_next;

    logic                m_valid_reg, m_valid_next;
    logic                m_target_reg, m_target_next;
    logic [ROW_W-1:0]    m_row_reg, m_row_next;
    logic [ROW_W-1:0]    m_column_reg, m_column_next;
    logic [DATA_W-1:0]   m_amount_reg, m_amount_next;
    logic                m_last_reg, m_last_next;
    logic [STAT_W-1:0]   m_status_reg, m_status_next;

    logic [ROW_W-1:0]    node_count;
    logic                accept;
    logic                p_nz, m_nz;
    logic                vs_full;
    logic [ROW_W-1:0]    vs_row;
    logic [DATA_W-1:0]   mag;
    logic                recip_start;
    logic                recip_done;
    logic [DATA_W:0]     recip_q;
    logic [DATA_W-1:0]   g_sat;
    logic                out_free;
    logic [SLOT_W-1:0]   sel;
    logic [SLOTS-1:0]    mask_left;
    logic                sl_target;
    logic [ROW_W-1:0]    sl_row, sl_col;
    logic [DATA_W-1:0]   sl_amount;

    mes_cfg #(
        .MAX_NODES (MAX_NODES)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .node_count (node_count)
    );

    mes_recip u_recip (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (recip_start),
        .divisor  (mag),
        .done     (recip_done),
        .quotient (recip_q)
    );

    assign pready  = 1'b1;
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign p_nz    = (s_node_plus != '0);
    assign m_nz    = (s_node_minus != '0);
    assign vs_full = (vidx_reg == VIDX_W'(MAX_VSOURCES));
    assign mag     = s_value[DATA_W-1] ? DATA_W'(-s_value) : s_value;

    // extra row wraps to the 9-bit field
    always_comb begin
        logic [SUM_W-1:0] sum;
        sum    = SUM_W'(node_count) - SUM_W'(1) + SUM_W'(vidx_reg);
        vs_row = sum[ROW_W-1:0];
    end

    // saturate the signed conductance
    always_comb begin
        if (!val_reg[DATA_W-1]) begin
            g_sat = (recip_q > {1'b0, Q_MAX}) ? Q_MAX : recip_q[DATA_W-1:0];
        end else begin
            g_sat = (recip_q > {1'b0, Q_MIN}) ? Q_MIN : DATA_W'(-recip_q[DATA_W-1:0]);
        end
    end

    // lowest pending entry first
    always_comb begin
        sel = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = SLOT_W'(i);
            end
        end
        mask_left      = mask_reg;
        mask_left[sel] = 1'b0;
    end

    always_comb begin
        sl_target = TARGET_MATRIX;
        sl_row    = '0;
        sl_col    = '0;
        sl_amount = '0;
        unique case (kind_reg)
            K_RES: begin
                unique case (sel)
                    3'd1: begin
                        sl_row = m1_reg; sl_col = m1_reg; sl_amount = g_reg;
                    end
                    3'd2: begin
                        sl_row = p1_reg; sl_col = m1_reg; sl_amount = sat_neg(g_reg);
                    end
                    3'd3: begin
                        sl_row = m1_reg; sl_col = p1_reg; sl_amount = sat_neg(g_reg);
                    end
                    default: begin
                        sl_row = p1_reg; sl_col = p1_reg; sl_amount = g_reg;
                    end
                endcase
            end
            K_CUR: begin
                sl_target = TARGET_RHS;
                if (sel == 3'd1) begin
                    sl_row = m1_reg; sl_amount = val_reg;
                end else begin
                    sl_row = p1_reg; sl_amount = sat_neg(val_reg);
                end
            end
            K_VS: begin
                unique case (sel)
                    3'd1: begin
                        sl_row = r_reg; sl_col = p1_reg; sl_amount = Q_ONE;
                    end
                    3'd2: begin
                        sl_row = m1_reg; sl_col = r_reg; sl_amount = Q_MINUS_ONE;
                    end
                    3'd3: begin
                        sl_row = r_reg; sl_col = m1_reg; sl_amount = Q_MINUS_ONE;
                    end
                    3'd4: begin
                        sl_target = TARGET_RHS; sl_row = r_reg; sl_amount = val_reg;
                    end
                    default: begin
                        sl_row = p1_reg; sl_col = r_reg; sl_amount = Q_ONE;
                    end
                endcase
            end
            default: begin
                // error entry stays all zero
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        vidx_next     = vidx_reg;
        p1_next       = p1_reg;
        m1_next       = m1_reg;
        r_next        = r_reg;
        val_next      = val_reg;
        g_next        = g_reg;
        recip_start   = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_target_next = m_target_reg;
        m_row_next    = m_row_reg;
        m_column_next = m_column_reg;
        m_amount_next = m_amount_reg;
        m_last_next   = m_last_reg;
        m_status_next = m_status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    p1_next     = ROW_W'(s_node_plus) - ROW_W'(1);
                    m1_next     = ROW_W'(s_node_minus) - ROW_W'(1);
                    r_next      = vs_row;
                    val_next    = s_value;
                    status_next = STATUS_OK;
                    mask_next   = '0;
                    unique case (s_command)
                        CMD_RESISTOR: begin
                            if (s_value == '0) begin
                                kind_next   = K_ERR;
                                status_next = STATUS_SHORT;
                                mask_next   = SLOTS'(1);
                            end else begin
                                kind_next = K_RES;
                                mask_next = {1'b0, p_nz && m_nz, p_nz && m_nz, m_nz, p_nz};
                            end
                        end
                        CMD_CURRENT: begin
                            kind_next = K_CUR;
                            mask_next = {3'b000, m_nz, p_nz};
                        end
                        CMD_VSOURCE: begin
                            if (vs_full) begin
                                kind_next   = K_ERR;
                                status_next = STATUS_OVERFLOW;
                                mask_next   = SLOTS'(1);
                            end else begin
                                kind_next = K_VS;
                                mask_next = {1'b1, m_nz, m_nz, p_nz, p_nz};
                                vidx_next = vidx_reg + VIDX_W'(1);
                            end
                        end
                        CMD_CLEAR: begin
                            vidx_next = '0;
                        end
                        default: begin
                            kind_next   = K_ERR;
                            status_next = STATUS_UNKNOWN;
                            mask_next   = SLOTS'(1);
                        end
                    endcase
                    if (mask_next != '0) begin
                        if (kind_next == K_RES) begin
                            recip_start = 1'b1;
                            state_next  = ST_DIV;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_DIV: begin
                if (recip_done) begin
                    g_next     = g_sat;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_target_next = sl_target;
                    m_row_next    = sl_row;
                    m_column_next = sl_col;
                    m_amount_next = sl_amount;
                    m_last_next   = (mask_left == '0);
                    m_status_next = status_reg;
                    mask_next     = mask_left;
                    if (mask_left == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mask_reg    <= '0;
            vidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            vidx_reg    <= vidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        status_reg   <= status_next;
        p1_reg       <= p1_next;
        m1_reg       <= m1_next;
        r_reg        <= r_next;
        val_reg      <= val_next;
        g_reg        <= g_next;
        m_target_reg <= m_target_next;
        m_row_reg    <= m_row_next;
        m_column_reg <= m_column_next;
        m_amount_reg <= m_amount_next;
        m_last_reg   <= m_last_next;
        m_status_reg <= m_status_next;
    end

    assign m_valid  = m_valid_reg;
    assign m_target = m_target_reg;
    assign m_row    = m_row_reg;
    assign m_column = m_column_reg;
    assign m_amount = m_amount_reg;
    assign m_last   = m_last_reg;
    assign m_status = m_status_reg;

endmodule

// ===== tb/mna_element_stamper_test.sv =====
// self-checking testbench of the mna element stamper
module mna_element_stamper_test;
    import mes_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 60;    // covers a resistor divide plus its entries
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SHOW_MAX      = 10;
    localparam int IDLE_PCT      = 36;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN_FIRST = 3'd4;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_MID   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LAST  = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]         command;
        logic [NODE_W-1:0]        node_plus;
        logic [NODE_W-1:0]        node_minus;
        logic signed [DATA_W-1:0] value;
    } element_t;

    typedef struct {
        logic              target;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  column;
        logic [DATA_W-1:0] amount;
        logic              last;
        logic [STAT_W-1:0] status;
    } stamp_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    logic [DATA_W-1:0]        prdata;
    logic                     pready;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [CMD_W-1:0]         s_command = '0;
    logic [NODE_W-1:0]        s_node_plus = '0;
    logic [NODE_W-1:0]        s_node_minus = '0;
    logic signed [DATA_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic                     m_target;
    logic [ROW_W-1:0]         m_row;
    logic [ROW_W-1:0]         m_column;
    logic signed [DATA_W-1:0] m_amount;
    logic                     m_last;
    logic [STAT_W-1:0]        m_status;

    element_t element_q[$];
    stamp_t   stamp_q[$];

    // mirror of the block's state
    logic [ROW_W-1:0] node_count = ROW_W'(DEF_MAX_NODES);
    logic [6:0]       vs_index = '0;

    int  failures = 0;
    int  src_idle_pct = IDLE_PCT;
    int  sink_idle_pct = IDLE_PCT;
    bit  hold_request = 1'b0;
    int  hold_left = 0;
    int  stall_cycles = 0;

    mna_element_stamper u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_node_plus  (s_node_plus),
        .s_node_minus (s_node_minus),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_target     (m_target),
        .m_row        (m_row),
        .m_column     (m_column),
        .m_amount     (m_amount),
        .m_last       (m_last),
        .m_status     (m_status)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [DATA_W-1:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647) begin
            return Q_MAX;
        end
        if (v < -64'sd2147483648) begin
            return Q_MIN;
        end
        return DATA_W'(v);
    endfunction

    function automatic stamp_t stamp_entry(input logic tgt, input logic [ROW_W-1:0] row,
                                           input logic [ROW_W-1:0] col,
                                           input logic [DATA_W-1:0] amt,
                                           input logic [STAT_W-1:0] st);
        stamp_t s;
        s.target = tgt;
        s.row    = row;
        s.column = col;
        s.amount = amt;
        s.last   = 1'b0;
        s.status = st;
        return s;
    endfunction

    // works out the stamp entries of one element and advances or clears the source index
    task automatic stamp_element(input element_t e);
        stamp_t            out[$];
        logic [ROW_W-1:0]  p;
        logic [ROW_W-1:0]  m;
        logic [ROW_W-1:0]  r;
        longint            v;
        longint            mag;
        longint            quo;
        logic [DATA_W-1:0] gp;
        logic [DATA_W-1:0] gn;
        p = ROW_W'(e.node_plus) - ROW_W'(1);
        m = ROW_W'(e.node_minus) - ROW_W'(1);
        v = longint'($signed(e.value));
        case (e.command)
            CMD_RESISTOR: begin
                if (v == 0) begin
                    out.push_back(stamp_entry(TARGET_MATRIX, '0, '0, '0, STATUS_SHORT));
                end else begin
                    mag = (v < 0) ? -v : v;
                    quo = (longint'(1) <<< 32) / mag;
                    gp  = clamp_q16((v < 0) ? -quo : quo);
                    gn  = clamp_q16(-longint'($signed(gp)));
                    if (e.node_plus != 0) begin
                        out.push_back(stamp_entry(TARGET_MATRIX, p, p, gp, STATUS_OK));
                    end
                    if (e.node_minus != 0) begin
                        out.push_back(stamp_entry(TARGET_MATRIX, m, m, gp, STATUS_OK));
                    end
                    if (e.node_plus != 0 && e.node_minus != 0) begin
                        out.push_back(stamp_entry(TARGET_MATRIX, p, m, gn, STATUS_OK));
                        out.push_back(stamp_entry(TARGET_MATRIX, m, p, gn, STATUS_OK));
                    end
                end
            end
            CMD_CURRENT: begin
                if (e.node_plus != 0) begin
                    out.push_back(stamp_entry(TARGET_RHS, p, '0, clamp_q16(-v), STATUS_OK));
                end
                if (e.node_minus != 0) begin
                    out.push_back(stamp_entry(TARGET_RHS, m, '0, e.value, STATUS_OK));
                end
            end
            CMD_VSOURCE: begin
                if (vs_index >= DEF_MAX_VSOURCES) begin
                    out.push_back(stamp_entry(TARGET_MATRIX, '0, '0, '0, STATUS_OVERFLOW));
                end else begin
                    r = node_count - ROW_W'(1) + ROW_W'(vs_index);
                    if (e.node_plus != 0) begin
                        out.push_back(stamp_entry(TARGET_MATRIX, p, r, Q_ONE, STATUS_OK));
                        out.push_back(stamp_entry(TARGET_MATRIX, r, p, Q_ONE, STATUS_OK));
                    end
                    if (e.node_minus != 0) begin
                        out.push_back(stamp_entry(TARGET_MATRIX, m, r, Q_MINUS_ONE, STATUS_OK));
                        out.push_back(stamp_entry(TARGET_MATRIX, r, m, Q_MINUS_ONE, STATUS_OK));
                    end
                    out.push_back(stamp_entry(TARGET_RHS, r, '0, e.value, STATUS_OK));
                    vs_index = vs_index + 7'd1;
                end
            end
            CMD_CLEAR: begin
                vs_index = '0;
            end
            default: begin
                out.push_back(stamp_entry(TARGET_MATRIX, '0, '0, '0, STATUS_UNKNOWN));
            end
        endcase
        if (out.size() != 0) begin
            out[out.size() - 1].last = 1'b1;
        end
        foreach (out[i]) begin
            stamp_q.push_back(out[i]);
        end
    endtask

    // driver: offers queued elements, predicts each one as it is accepted
    always @(posedge aclk) begin
        element_t e;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                e.command    = s_command;
                e.node_plus  = s_node_plus;
                e.node_minus = s_node_minus;
                e.value      = s_value;
                stamp_element(e);
            end
            if (!s_valid || s_ready) begin
                if (element_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    e = element_q.pop_front();
                    s_command    <= e.command;
                    s_node_plus  <= e.node_plus;
                    s_node_minus <= e.node_minus;
                    s_value      <= e.value;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // monitor: each accepted result against the oldest expected entry
    always @(posedge aclk) begin
        stamp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (stamp_q.size() == 0) begin
                if (failures < SHOW_MAX) begin
                    $display("unexpected result: tgt %0d row %0d col %0d amt %h last %0d st %0d",
                             m_target, m_row, m_column, m_amount, m_last, m_status);
                end
                failures++;
            end else begin
                want = stamp_q.pop_front();
                if (m_target !== want.target || m_row !== want.row ||
                    m_column !== want.column || m_amount !== want.amount ||
                    m_last !== want.last || m_status !== want.status) begin
                    if (failures < SHOW_MAX) begin
                        $display("mismatch: expected tgt %0d row %0d col %0d amt %h last %0d st %0d",
                                 want.target, want.row, want.column, want.amount,
                                 want.last, want.status);
                        $display("          got      tgt %0d row %0d col %0d amt %h last %0d st %0d",
                                 m_target, m_row, m_column, m_amount, m_last, m_status);
                    end
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_node_count(input logic [DATA_W-1:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NODE_COUNT;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // register takes 0 as 1 and clamps to the node limit
        node_count = data[ROW_W-1:0];
        if (node_count == 0) begin
            node_count = ROW_W'(1);
        end else if (node_count > DEF_MAX_NODES) begin
            node_count = ROW_W'(DEF_MAX_NODES);
        end
        @(negedge aclk);
    endtask

    task automatic add_element(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] np,
                               input logic [NODE_W-1:0] nm, input logic [DATA_W-1:0] val);
        element_t e;
        e.command    = cmd;
        e.node_plus  = np;
        e.node_minus = nm;
        e.value      = val;
        element_q.push_back(e);
    endtask

    function automatic logic [NODE_W-1:0] random_node();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return '1;
            default: return NODE_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        logic [DATA_W-1:0] mag;
        case ($urandom_range(0, 9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return DATA_W'(1);
            3:       return '1;
            4, 5: begin
                mag = $urandom_range(1, 32'h0003_0000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            default: return $urandom;
        endcase
    endfunction

    // mixed elements, or mostly voltage sources when filling the source rows
    task automatic add_random(input int count, input bit vsource_run);
        element_t e;
        int       pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (vsource_run) begin
                e.command = (pick < 97) ? CMD_VSOURCE
                          : ((pick < 99) ? CMD_RESISTOR : CMD_CURRENT);
            end else if (pick < 40) begin
                e.command = CMD_RESISTOR;
            end else if (pick < 65) begin
                e.command = CMD_CURRENT;
            end else if (pick < 88) begin
                e.command = CMD_VSOURCE;
            end else if (pick < 94) begin
                e.command = CMD_CLEAR;
            end else begin
                e.command = CMD_W'($urandom_range(CMD_UNKNOWN_FIRST, CMD_UNKNOWN_LAST));
            end
            e.node_plus  = random_node();
            e.node_minus = ($urandom_range(0, 9) == 0) ? e.node_plus : random_node();
            e.value      = random_value();
            if (e.command == CMD_RESISTOR && $urandom_range(0, 14) == 0) begin
                e.value = '0;
            end
            element_q.push_back(e);
        end
    endtask

    // waits until every element is sent and every expected entry has arrived, then lets the block go quiet
    task automatic drain();
        while (element_q.size() != 0 || s_valid || stamp_q.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed elements at the reset node count
        add_element(CMD_RESISTOR, 8'd1, 8'd2, Q_ONE);
        add_element(CMD_RESISTOR, 8'd255, 8'd0, 32'd1);
        add_element(CMD_RESISTOR, 8'd7, 8'd7, '1);
        add_element(CMD_RESISTOR, 8'd0, 8'd0, 32'h0002_0000);
        add_element(CMD_RESISTOR, 8'd3, 8'd4, '0);
        add_element(CMD_RESISTOR, 8'd10, 8'd20, Q_MAX);
        add_element(CMD_RESISTOR, 8'd20, 8'd10, Q_MIN);
        add_element(CMD_RESISTOR, 8'd0, 8'd255, 32'hFFFF_8000);
        add_element(CMD_CURRENT, 8'd1, 8'd2, Q_MIN);
        add_element(CMD_CURRENT, 8'd255, 8'd0, Q_MAX);
        add_element(CMD_CURRENT, 8'd0, 8'd0, 32'd5);
        add_element(CMD_CURRENT, 8'd0, 8'd9, Q_MINUS_ONE);
        add_element(CMD_VSOURCE, 8'd0, 8'd0, Q_ONE);
        add_element(CMD_VSOURCE, 8'd255, 8'd1, Q_MIN);
        add_element(CMD_VSOURCE, 8'd5, 8'd0, Q_MAX);
        add_element(CMD_VSOURCE, 8'd0, 8'd6, '1);
        add_element(CMD_CLEAR, 8'd255, 8'd255, '1);
        add_element(CMD_VSOURCE, 8'd2, 8'd3, 32'h0001_2345);
        add_element(CMD_UNKNOWN_FIRST, 8'd1, 8'd1, Q_ONE);
        add_element(CMD_UNKNOWN_LAST, 8'd255, 8'd0, Q_MIN);
        add_element(CMD_UNKNOWN_MID, 8'd0, 8'd255, Q_MAX);
        drain();

        write_node_count(32'd1);
        add_random(10, 1'b0);
        drain();

        // no idling on either side while the source rows fill up and overflow
        write_node_count(32'h0000_01FF);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        add_element(CMD_CLEAR, '0, '0, '0);
        add_random(72, 1'b1);
        drain();
        src_idle_pct  = IDLE_PCT;
        sink_idle_pct = IDLE_PCT;

        // receiver stalls while the sender keeps offering
        write_node_count(32'd0);
        hold_request = 1'b1;
        add_random(10, 1'b0);
        drain();

        write_node_count(32'($urandom_range(2, 255)));
        add_random(10, 1'b0);
        drain();

        if (failures == 0 && stamp_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
